/* hdl/swept_sphere_impact_time_assert.svh */
// ---------------------------------------------------------------------------
// swept_sphere_impact_time assertion macros
// shared assertion forms, compiled out when NO_ASSERTIONS is set
// ---------------------------------------------------------------------------
`ifndef SWEPT_SPHERE_IMPACT_TIME_ASSERT_SVH
`define SWEPT_SPHERE_IMPACT_TIME_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every clock edge out of reset
`define SSIT_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// antecedent implies consequent
`define SSIT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define SSIT_ASSERT(label, cond, msg)
`define SSIT_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

/* hdl/ssit_pkg.sv */
// ---------------------------------------------------------------------------
// ssit_pkg
// shared types and constants of the swept sphere impact time pipeline
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssit_pkg;

    localparam int TIME_W       = 31;
    localparam int SQRT_CELLS   = 64;
    localparam int DIV_CELLS    = 31;
    localparam int FRONT_STAGES = 8;

    // data riding alongside each beat through the cell chains
    typedef struct packed {
        logic              decided;
        logic              early_hit;
        logic [63:0]       b;
        logic [63:0]       vsq;
        logic [TIME_W-1:0] horizon;
    } side_t;

    // square root working state
    typedef struct packed {
        logic [63:0]  root;
        logic [127:0] rem;
    } sqrt_t;

endpackage

`default_nettype wire

/* hdl/ssit_sqrt_cell.sv */
// ---------------------------------------------------------------------------
// ssit_sqrt_cell
// one root bit of the restoring square root, one register stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssit_sqrt_cell #(
    parameter int K = 63
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    input  wire ssit_pkg::side_t in_side,
    input  wire ssit_pkg::sqrt_t in_sq,
    output logic                 out_valid,
    output ssit_pkg::side_t      out_side,
    output ssit_pkg::sqrt_t      out_sq
);
    import ssit_pkg::*;

    logic        valid_reg;
    side_t       side_reg;
    sqrt_t       sq_reg;
    sqrt_t       sq_next;
    logic [129:0] trial;
    logic [129:0] rem_ext;

    // (root + 2^K)^2 - root^2 against the remainder
    always_comb
    begin
        trial   = ({66'd0, in_sq.root} << (K + 1)) + (130'd1 << (2 * K));
        rem_ext = {2'b00, in_sq.rem};
        sq_next = in_sq;
        if (rem_ext >= trial)
        begin
            sq_next.rem  = in_sq.rem - trial[127:0];
            sq_next.root = in_sq.root | (64'd1 << K);
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        sq_reg   <= sq_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_sq    = sq_reg;

endmodule

`default_nettype wire

/* hdl/ssit_div_cell.sv */
// ---------------------------------------------------------------------------
// ssit_div_cell
// one quotient bit of the restoring divide, one register stage
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssit_div_cell #(
    parameter int I     = 30,
    parameter int NUM_W = 80
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire ssit_pkg::side_t               in_side,
    input  wire logic [NUM_W-1:0]              in_rem,
    input  wire logic [ssit_pkg::TIME_W-1:0]   in_quot,
    output logic                               out_valid,
    output ssit_pkg::side_t                    out_side,
    output logic [NUM_W-1:0]                   out_rem,
    output logic [ssit_pkg::TIME_W-1:0]        out_quot
);
    import ssit_pkg::*;

    logic                 valid_reg;
    side_t                side_reg;
    logic [NUM_W-1:0]     rem_reg;
    logic [NUM_W-1:0]     rem_next;
    logic [TIME_W-1:0]    quot_reg;
    logic [TIME_W-1:0]    quot_next;
    logic [NUM_W+30:0]    dvs;
    logic [NUM_W+30:0]    rem_ext;

    // subtract the shifted divisor where it fits
    always_comb
    begin
        dvs       = (NUM_W + 31)'(in_side.vsq) << I;
        rem_ext   = (NUM_W + 31)'(in_rem);
        rem_next  = in_rem;
        quot_next = in_quot;
        if (rem_ext >= dvs)
        begin
            rem_next  = NUM_W'(rem_ext - dvs);
            quot_next = in_quot | (TIME_W'(1) << I);
        end
    end

    // beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    // payload
    always_ff @(posedge clk)
    begin
        side_reg <= in_side;
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
    end

    assign out_valid = valid_reg;
    assign out_side  = side_reg;
    assign out_rem   = rem_reg;
    assign out_quot  = quot_reg;

endmodule

`default_nettype wire

/* hdl/swept_sphere_impact_time.sv */
// ---------------------------------------------------------------------------
// swept_sphere_impact_time
// first contact time of two moving spheres within a time horizon
// ---------------------------------------------------------------------------
// A new sphere pair is taken in every clock cycle (busy stays low) and its
// result appears on done, hit and impact_time exactly 105 cycles after the
// start beat, in order, for one cycle only: the receiver must take it then.
// The latency is set by eight front stages (input register, magnitudes,
// products, sums, classification, split 64x64 products, their sums,
// discriminant), a chain of 64 square root cells, one stage forming the
// numerator, 31 divide cells and the output register. There is no reset
// sweep or other dead time.
`timescale 1ns / 1ps
`default_nettype none
`include "swept_sphere_impact_time_assert.svh"

module swept_sphere_impact_time #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [30:0]                 first_radius,
    input  wire logic [30:0]                 second_radius,
    input  wire logic signed [31:0]          offset_x,
    input  wire logic signed [31:0]          offset_y,
    input  wire logic signed [31:0]          offset_z,
    input  wire logic signed [31:0]          vel_x,
    input  wire logic signed [31:0]          vel_y,
    input  wire logic signed [31:0]          vel_z,
    input  wire logic [ssit_pkg::TIME_W-1:0] time_horizon,
    output logic                             done,
    output logic                             hit,
    output logic [ssit_pkg::TIME_W-1:0]      impact_time
);
    import ssit_pkg::*;

    localparam int NUM_W   = 64 + FRAC_BITS;
    localparam int LATENCY = FRONT_STAGES + SQRT_CELLS + 1 + DIV_CELLS + 1;

    logic [FRONT_STAGES:1] fv_reg;

    // stage 1: raw inputs
    logic [31:0]       s1_o_reg [3];
    logic [31:0]       s1_v_reg [3];
    logic [31:0]       s1_rsum_reg;
    logic [TIME_W-1:0] s1_h_reg;

    // stage 2: magnitudes
    logic [31:0]       s2_om_reg [3];
    logic [31:0]       s2_vm_reg [3];
    logic [2:0]        s2_sd_reg;
    logic [31:0]       s2_rsum_reg;
    logic [TIME_W-1:0] s2_h_reg;

    // stage 3: products
    logic [63:0]       s3_oo_reg [3];
    logic [63:0]       s3_vv_reg [3];
    logic [63:0]       s3_ov_reg [3];
    logic [2:0]        s3_sd_reg;
    logic [63:0]       s3_r2_reg;
    logic [TIME_W-1:0] s3_h_reg;

    // stage 4: sums
    logic [63:0]       s4_osq_reg;
    logic [63:0]       s4_vsq_reg;
    logic [63:0]       s4_pos_reg;
    logic [63:0]       s4_neg_reg;
    logic [63:0]       s4_r2_reg;
    logic [TIME_W-1:0] s4_h_reg;
    logic [63:0]       osq_next;
    logic [63:0]       vsq_next;
    logic [63:0]       pos_next;
    logic [63:0]       neg_next;

    // stage 5: classification
    side_t             s5_side_reg;
    side_t             s5_side_next;
    logic [63:0]       s5_c_reg;

    // stage 6: partial products
    side_t             s6_side_reg;
    logic [63:0]       bb_hh_reg;
    logic [63:0]       bb_hl_reg;
    logic [63:0]       bb_ll_reg;
    logic [63:0]       ac_hh_reg;
    logic [63:0]       ac_hl_reg;
    logic [63:0]       ac_lh_reg;
    logic [63:0]       ac_ll_reg;

    // stage 7: full products
    side_t             s7_side_reg;
    logic [127:0]      s7_bb_reg;
    logic [127:0]      s7_ac_reg;

    // stage 8: discriminant
    side_t             s8_side_reg;
    side_t             s8_side_next;
    sqrt_t             s8_sq_reg;

    // square root chain
    logic              sq_valid [SQRT_CELLS+1];
    side_t             sq_side  [SQRT_CELLS+1];
    sqrt_t             sq_data  [SQRT_CELLS+1];

    // numerator stage
    logic              nm_valid_reg;
    side_t             nm_side_reg;
    side_t             nm_side_next;
    logic [NUM_W-1:0]  nm_num_reg;
    logic [NUM_W-1:0]  num_next;
    logic [63:0]       n_val;
    logic [NUM_W+31:0] over_lim;

    // divide chain
    logic              dv_valid [DIV_CELLS+1];
    side_t             dv_side  [DIV_CELLS+1];
    logic [NUM_W-1:0]  dv_rem   [DIV_CELLS+1];
    logic [TIME_W-1:0] dv_quot  [DIV_CELLS+1];

    // output
    logic              done_reg;
    logic              hit_reg;
    logic              hit_next;
    logic [TIME_W-1:0] time_reg;
    logic              in_time;

    assign busy = 1'b0;

    // front valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= '0;
        else
            fv_reg <= {fv_reg[FRONT_STAGES-1:1], start & ~busy};
    end

    // stages 1 to 3
    always_ff @(posedge clk)
    begin
        s1_o_reg[0] <= offset_x;
        s1_o_reg[1] <= offset_y;
        s1_o_reg[2] <= offset_z;
        s1_v_reg[0] <= vel_x;
        s1_v_reg[1] <= vel_y;
        s1_v_reg[2] <= vel_z;
        s1_rsum_reg <= {1'b0, first_radius} + {1'b0, second_radius};
        s1_h_reg    <= time_horizon;
        for (int i = 0; i < 3; i++)
        begin
            s2_om_reg[i] <= s1_o_reg[i][31] ? (~s1_o_reg[i] + 32'd1) : s1_o_reg[i];
            s2_vm_reg[i] <= s1_v_reg[i][31] ? (~s1_v_reg[i] + 32'd1) : s1_v_reg[i];
            s2_sd_reg[i] <= s1_o_reg[i][31] ^ s1_v_reg[i][31];
            s3_oo_reg[i] <= 64'(s2_om_reg[i]) * 64'(s2_om_reg[i]);
            s3_vv_reg[i] <= 64'(s2_vm_reg[i]) * 64'(s2_vm_reg[i]);
            s3_ov_reg[i] <= 64'(s2_om_reg[i]) * 64'(s2_vm_reg[i]);
        end
        s2_rsum_reg <= s1_rsum_reg;
        s2_h_reg    <= s1_h_reg;
        s3_sd_reg   <= s2_sd_reg;
        s3_r2_reg   <= 64'(s2_rsum_reg) * 64'(s2_rsum_reg);
        s3_h_reg    <= s2_h_reg;
    end

    // dot products split by sign of each term
    always_comb
    begin
        osq_next = s3_oo_reg[0] + s3_oo_reg[1] + s3_oo_reg[2];
        vsq_next = s3_vv_reg[0] + s3_vv_reg[1] + s3_vv_reg[2];
        pos_next = '0;
        neg_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (s3_sd_reg[i])
                neg_next = neg_next + s3_ov_reg[i];
            else
                pos_next = pos_next + s3_ov_reg[i];
        end
    end

    // classify: still, touching, separating or approaching
    always_comb
    begin
        s5_side_next.b         = s4_neg_reg - s4_pos_reg;
        s5_side_next.vsq       = s4_vsq_reg;
        s5_side_next.horizon   = s4_h_reg;
        s5_side_next.decided   = 1'b1;
        s5_side_next.early_hit = 1'b0;
        if (s4_vsq_reg == '0)
            s5_side_next.early_hit = (s4_osq_reg < s4_r2_reg);
        else if (s4_osq_reg <= s4_r2_reg)
            s5_side_next.early_hit = 1'b1;
        else if (s4_neg_reg > s4_pos_reg)
            s5_side_next.decided = 1'b0;
    end

    // negative discriminant settles an approach as a miss
    always_comb
    begin
        s8_side_next = s7_side_reg;
        if (s7_ac_reg > s7_bb_reg)
        begin
            s8_side_next.decided   = 1'b1;
            s8_side_next.early_hit = s7_side_reg.decided & s7_side_reg.early_hit;
        end
    end

    // stages 4 to 8
    always_ff @(posedge clk)
    begin
        s4_osq_reg  <= osq_next;
        s4_vsq_reg  <= vsq_next;
        s4_pos_reg  <= pos_next;
        s4_neg_reg  <= neg_next;
        s4_r2_reg   <= s3_r2_reg;
        s4_h_reg    <= s3_h_reg;

        s5_side_reg <= s5_side_next;
        s5_c_reg    <= s4_osq_reg - s4_r2_reg;

        s6_side_reg <= s5_side_reg;
        bb_hh_reg   <= 64'(s5_side_reg.b[63:32]) * 64'(s5_side_reg.b[63:32]);
        bb_hl_reg   <= 64'(s5_side_reg.b[63:32]) * 64'(s5_side_reg.b[31:0]);
        bb_ll_reg   <= 64'(s5_side_reg.b[31:0]) * 64'(s5_side_reg.b[31:0]);
        ac_hh_reg   <= 64'(s5_side_reg.vsq[63:32]) * 64'(s5_c_reg[63:32]);
        ac_hl_reg   <= 64'(s5_side_reg.vsq[63:32]) * 64'(s5_c_reg[31:0]);
        ac_lh_reg   <= 64'(s5_side_reg.vsq[31:0]) * 64'(s5_c_reg[63:32]);
        ac_ll_reg   <= 64'(s5_side_reg.vsq[31:0]) * 64'(s5_c_reg[31:0]);

        s7_side_reg <= s6_side_reg;
        s7_bb_reg   <= ({bb_hh_reg, 64'd0}) + (128'(bb_hl_reg) << 33) + 128'(bb_ll_reg);
        s7_ac_reg   <= ({ac_hh_reg, 64'd0}) + (128'(ac_hl_reg) << 32)
                       + (128'(ac_lh_reg) << 32) + 128'(ac_ll_reg);

        s8_side_reg <= s8_side_next;
        s8_sq_reg   <= {64'd0, s7_bb_reg - s7_ac_reg};
    end

    // square root cell chain, most significant root bit first
    assign sq_valid[0] = fv_reg[FRONT_STAGES];
    assign sq_side[0]  = s8_side_reg;
    assign sq_data[0]  = s8_sq_reg;

    for (genvar j = 0; j < SQRT_CELLS; j++)
    begin : g_sqrt
        ssit_sqrt_cell #(
            .K (SQRT_CELLS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (sq_valid[j]),
            .in_side   (sq_side[j]),
            .in_sq     (sq_data[j]),
            .out_valid (sq_valid[j+1]),
            .out_side  (sq_side[j+1]),
            .out_sq    (sq_data[j+1])
        );
    end

    // numerator and quotient range check
    always_comb
    begin
        n_val        = sq_side[SQRT_CELLS].b - sq_data[SQRT_CELLS].root;
        num_next     = NUM_W'(n_val) << FRAC_BITS;
        over_lim     = (NUM_W + 32)'(sq_side[SQRT_CELLS].vsq) << TIME_W;
        nm_side_next = sq_side[SQRT_CELLS];
        if (!sq_side[SQRT_CELLS].decided && ((NUM_W + 32)'(num_next) >= over_lim))
        begin
            nm_side_next.decided   = 1'b1;
            nm_side_next.early_hit = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            nm_valid_reg <= 1'b0;
        else
            nm_valid_reg <= sq_valid[SQRT_CELLS];
    end

    always_ff @(posedge clk)
    begin
        nm_side_reg <= nm_side_next;
        nm_num_reg  <= num_next;
    end

    // divide cell chain
    assign dv_valid[0] = nm_valid_reg;
    assign dv_side[0]  = nm_side_reg;
    assign dv_rem[0]   = nm_num_reg;
    assign dv_quot[0]  = '0;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        ssit_div_cell #(
            .I     (DIV_CELLS - 1 - j),
            .NUM_W (NUM_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (dv_valid[j]),
            .in_side   (dv_side[j]),
            .in_rem    (dv_rem[j]),
            .in_quot   (dv_quot[j]),
            .out_valid (dv_valid[j+1]),
            .out_side  (dv_side[j+1]),
            .out_rem   (dv_rem[j+1]),
            .out_quot  (dv_quot[j+1])
        );
    end

    // final verdict against the horizon
    always_comb
    begin
        in_time  = (dv_quot[DIV_CELLS] <= dv_side[DIV_CELLS].horizon);
        hit_next = dv_side[DIV_CELLS].decided ? dv_side[DIV_CELLS].early_hit : in_time;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid[DIV_CELLS];
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        time_reg <= (!dv_side[DIV_CELLS].decided && in_time) ? dv_quot[DIV_CELLS] : '0;
    end

    assign done        = done_reg;
    assign hit         = hit_reg;
    assign impact_time = time_reg;

    // checks
    `SSIT_ASSERT_IMP(a_latency, start && !busy, ##LATENCY done, "result beat missing")
    `SSIT_ASSERT_IMP(a_no_stray, done, $past(start, LATENCY), "result without start beat")
    `SSIT_ASSERT_IMP(a_miss_time, done && !hit, impact_time == '0, "miss with nonzero time")

endmodule

`default_nettype wire
